### design/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg: shared types and constants for the matrix-vector multiplier
// Store sizes, field widths, item codes and the multiply-accumulate control.
// ----------------------------------------------------------------------------
package mvm_pkg;

	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int RESULT_CAP = 16;
	localparam int ROW_CAP    = (MAX_ROWS < RESULT_CAP) ? MAX_ROWS : RESULT_CAP;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int IDX_W     = 4;
	localparam int KIND_W    = 2;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_MAX = (MAX_COLS > ROW_CAP) ? MAX_COLS : ROW_CAP;
	localparam int CNT_W  = $clog2(CNT_MAX + 1);
	// Products are Q32.32; a sum of MAX_COLS of them fits in COL_W + 1 more bits.
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + COL_W + 1;

	localparam int IN_TDATA_W  = ((2 * IDX_W + DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - IDX_W;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_MAT = 2'd0,
		KIND_LOAD_VEC = 2'd1,
		KIND_START    = 2'd2
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd2;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_DIM_ERR = 1'b1;

	typedef struct packed {
		logic clear;
		logic vld;
		logic last;
	} mac_ctrl_t;

	// Saturates a configured count into the range 1..hi.
	function automatic int clamp_count(logic [CFG_W-1:0] v, int hi);
		int r;
		r = int'(v);
		if (r < 1) begin
			r = 1;
		end else if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

### design/mvm_mac.sv
// ----------------------------------------------------------------------------
// mvm_mac: shared multiply-accumulate unit
// One signed 32x32 product per cycle into a wide accumulator, with the final
// sum truncated to Q16.16 and saturated when the last column arrives.
// ----------------------------------------------------------------------------
module mvm_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mvm_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [mvm_pkg::DATA_W-1:0]  mat_elem,
	input  logic signed [mvm_pkg::DATA_W-1:0]  vec_elem,
	output logic                               done,
	output logic signed [mvm_pkg::DATA_W-1:0]  sum_sat
);
	import mvm_pkg::*;

	logic signed [PROD_W-1:0]         prod_s2;
	logic                             vld_s2;
	logic                             last_s2;
	logic signed [ACC_W-1:0]          acc_q;
	logic signed [ACC_W-1:0]          acc_next;
	logic [ACC_W-FRAC_W-DATA_W:0]     upper;
	logic                             fits;
	logic                             done_q;
	logic signed [DATA_W-1:0]         res_q;

	assign acc_next = acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	// The Q16.16 result fits when every bit from its sign bit upward agrees.
	assign upper = acc_next[ACC_W-1:FRAC_W+DATA_W-1];
	assign fits  = (&upper) | ~(|upper);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s2  <= ctrl.vld;
			last_s2 <= ctrl.vld & ctrl.last;
			done_q  <= vld_s2 & last_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mat_elem * vec_elem;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_next;
		end
		if (vld_s2 && last_s2) begin
			if (fits) begin
				res_q <= acc_next[FRAC_W+DATA_W-1:FRAC_W];
			end else begin
				res_q <= acc_next[ACC_W-1] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	assign done    = done_q;
	assign sum_sat = res_q;

endmodule

### design/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply: Q16.16 matrix times vector
// Element stores loaded by index; a start item streams one dot product per row.
// ----------------------------------------------------------------------------
// Load items (matrix or vector element) give no result.
// A start item runs every active row through a single shared multiplier fed
// from one read port of each store, one column per cycle: each row first claims
// the output register, then issues its columns, then drains the read, product
// and accumulate stages. Input is accepted again once the last result is in
// the output register, even while it is still waiting to be taken. If the
// column count and the vector length differ, the start item gives one result
// with status set and no products. The user must write registers through the
// cfg port only while the block is idle; the block does not enforce this.
// Index 3 is ignored.
// ----------------------------------------------------------------------------
module matrix_vector_multiply (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration writes.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mvm_pkg::CFG_W-1:0]            cfg_data,
	// Input items.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mvm_pkg::IN_TDATA_W-1:0]       s_tdata,  // row[3:0], col[7:4], value[39:8]
	input  logic [mvm_pkg::KIND_W-1:0]           s_tuser,  // kind[1:0]
	// Result items.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mvm_pkg::OUT_TDATA_W-1:0]      m_tdata,  // out_value[31:0], out_row[35:32]
	output logic                                 m_tlast,
	output logic                                 m_tuser   // status
);
	import mvm_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		WAIT_OUT,
		ISSUE,
		DRAIN
	} state_t;

	state_t                    state_q;
	logic [CFG_W-1:0]          rows_cfg_q;
	logic [CFG_W-1:0]          cols_cfg_q;
	logic [CFG_W-1:0]          vlen_cfg_q;
	logic [CNT_W-1:0]          nrows_q;
	logic [CNT_W-1:0]          ncols_q;
	logic                      err_q;
	logic [IDX_W-1:0]          row_q;
	logic [COL_W-1:0]          col_q;

	logic [DATA_W-1:0]         mat_mem [DEPTH];
	logic [DATA_W-1:0]         vec_mem [MAX_COLS];
	logic signed [DATA_W-1:0]  mat_rd_s1;
	logic signed [DATA_W-1:0]  vec_rd_s1;
	logic                      vld_s1;
	logic                      last_s1;

	logic                      out_vld_q;
	logic signed [DATA_W-1:0]  out_value_q;
	logic [IDX_W-1:0]          out_row_q;
	logic                      out_last_q;
	logic                      out_status_q;

	logic [IDX_W-1:0]          in_row;
	logic [IDX_W-1:0]          in_col;
	logic [DATA_W-1:0]         in_value;
	kind_t                     in_kind;
	logic                      in_acc;
	logic                      out_free;
	logic                      col_last;
	logic                      row_last;
	logic [ADDR_W-1:0]         rd_addr;
	logic [ADDR_W-1:0]         wr_addr;

	mac_ctrl_t                 mac_ctrl;
	logic                      mac_done;
	logic signed [DATA_W-1:0]  mac_sum;

	assign in_row   = s_tdata[IDX_W-1:0];
	assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
	assign in_value = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
	assign in_kind  = kind_t'(s_tuser);

	assign s_tready  = (state_q == IDLE);
	assign in_acc    = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = ~out_vld_q | m_tready;

	assign col_last = (int'(col_q) + 1 == int'(ncols_q));
	assign row_last = (int'(row_q) + 1 == int'(nrows_q));
	assign rd_addr  = ADDR_W'(int'(row_q) * MAX_COLS + int'(col_q));
	assign wr_addr  = ADDR_W'(int'(in_row) * MAX_COLS + int'(in_col));

	always_comb begin
		mac_ctrl.clear = (state_q == WAIT_OUT) && out_free && !err_q;
		mac_ctrl.vld   = vld_s1;
		mac_ctrl.last  = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= CFG_W'(16);
			cols_cfg_q <= CFG_W'(16);
			vlen_cfg_q <= CFG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS_IN_USE:   rows_cfg_q <= cfg_data;
				REG_COLS_IN_USE:   cols_cfg_q <= cfg_data;
				REG_VECTOR_LENGTH: vlen_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Element stores: written by load items, read one element per cycle.
	always_ff @(posedge clk) begin
		if (in_acc && in_kind == KIND_LOAD_MAT && int'(in_row) < MAX_ROWS &&
				int'(in_col) < MAX_COLS) begin
			mat_mem[wr_addr] <= in_value;
		end
		if (in_acc && in_kind == KIND_LOAD_VEC && int'(in_col) < MAX_COLS) begin
			vec_mem[COL_W'(in_col)] <= in_value;
		end
		mat_rd_s1 <= mat_mem[rd_addr];
		vec_rd_s1 <= vec_mem[col_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			nrows_q      <= '0;
			ncols_q      <= '0;
			err_q        <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
			out_vld_q    <= 1'b0;
			out_value_q  <= '0;
			out_row_q    <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= STATUS_OK;
		end else begin
			vld_s1  <= (state_q == ISSUE);
			last_s1 <= (state_q == ISSUE) && col_last;
			// The error result reloads the register in the cycle the old one leaves.
			if (out_vld_q && m_tready && !(state_q == WAIT_OUT && err_q)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_acc && in_kind == KIND_START) begin
						nrows_q <= CNT_W'(clamp_count(rows_cfg_q, ROW_CAP));
						ncols_q <= CNT_W'(clamp_count(cols_cfg_q, MAX_COLS));
						err_q   <= clamp_count(cols_cfg_q, MAX_COLS) !=
							clamp_count(vlen_cfg_q, MAX_COLS);
						row_q   <= '0;
						col_q   <= '0;
						state_q <= WAIT_OUT;
					end
				end
				WAIT_OUT: begin
					if (out_free) begin
						if (err_q) begin
							out_vld_q    <= 1'b1;
							out_value_q  <= '0;
							out_row_q    <= '0;
							out_last_q   <= 1'b1;
							out_status_q <= STATUS_DIM_ERR;
							state_q      <= IDLE;
						end else begin
							state_q <= ISSUE;
						end
					end
				end
				ISSUE: begin
					if (col_last) begin
						col_q   <= '0;
						state_q <= DRAIN;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				DRAIN: begin
					if (mac_done) begin
						out_vld_q    <= 1'b1;
						out_value_q  <= mac_sum;
						out_row_q    <= row_q;
						out_last_q   <= row_last;
						out_status_q <= STATUS_OK;
						if (row_last) begin
							state_q <= IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= WAIT_OUT;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	mvm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.mat_elem (mat_rd_s1),
		.vec_elem (vec_rd_s1),
		.done     (mac_done),
		.sum_sat  (mac_sum)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_row_q, out_value_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

	// A finished row sum only shows up while its row is draining.
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == DRAIN)
		else $error("accumulator finished outside the drain phase");

	// A row is only started once the output register has room for its result.
	a_issue_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ISSUE |-> !out_vld_q)
		else $error("row issued while a result was still pending");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DRAIN && mac_done) |-> !out_vld_q)
		else $error("row result would overwrite an untaken result");

	// An error result always ends its run.
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_status_q == STATUS_DIM_ERR) |-> out_last_q)
		else $error("dimension error result not marked last");

	a_pipe_empty_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctrl.clear |-> !vld_s1 && !mac_done)
		else $error("accumulator cleared with products in flight");

endmodule
